/* rtl/ese_pkg.sv */
package ese_pkg;

	// fixed field widths
	localparam int VAL_W = 32;
	localparam int POS_W = 10;
	localparam int CFG_W = 11;

	typedef logic [POS_W-1:0]        pos_t;
	typedef logic [CFG_W-1:0]        cfg_t;
	typedef logic signed [VAL_W-1:0] val_t;

	// item opcodes
	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	// controller to datapath commands
	typedef struct packed {
		logic do_write;     // store value at index
		logic load_search;  // latch key, read entry 0
		logic probe_go;     // advance probe and read it
		logic probe_end;    // freeze final probe value
		logic bin_init;     // set up binary range, read midpoint
		logic bin_next;     // narrow range, read new midpoint
		logic finish_hit;   // report found at last read address
		logic finish_miss;  // report not found
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic count_zero;    // no entries take part
		logic eq;            // read entry equals key
		logic le;            // read entry at most key
		logic next_in;       // next probe below count
		logic init_range_ok; // initial binary range not empty
		logic next_range_ok; // narrowed binary range not empty
	} stat_t;

endpackage

/* rtl/ese_ctrl.sv */
module ese_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          opcode,
	input  ese_pkg::stat_t stat,
	output ese_pkg::cmd_t  cmd,
	output logic          busy,
	output logic          done
);
	import ese_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_CHECK0  = 5'b00010,
		S_PROBE   = 5'b00100,
		S_BSETUP  = 5'b01000,
		S_BSEARCH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (op_t'(opcode) == OP_WRITE) begin
						cmd.do_write = 1'b1;
					end else if (stat.count_zero) begin
						cmd.finish_miss = 1'b1;
					end else begin
						cmd.load_search = 1'b1;
						state_d         = S_CHECK0;
					end
				end
			end
			S_CHECK0: begin
				if (stat.eq) begin
					cmd.finish_hit = 1'b1;
					state_d        = S_IDLE;
				end else if (stat.next_in) begin
					cmd.probe_go = 1'b1;
					state_d      = S_PROBE;
				end else begin
					cmd.probe_end = 1'b1;
					state_d       = S_BSETUP;
				end
			end
			S_PROBE: begin
				if (stat.le && stat.next_in) begin
					cmd.probe_go = 1'b1;
				end else begin
					cmd.probe_end = 1'b1;
					state_d       = S_BSETUP;
				end
			end
			S_BSETUP: begin
				if (stat.init_range_ok) begin
					cmd.bin_init = 1'b1;
					state_d      = S_BSEARCH;
				end else begin
					cmd.finish_miss = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_BSEARCH: begin
				if (stat.eq) begin
					cmd.finish_hit = 1'b1;
					state_d        = S_IDLE;
				end else if (stat.next_range_ok) begin
					cmd.bin_next = 1'b1;
				end else begin
					cmd.finish_miss = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish_hit | cmd.finish_miss;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

/* rtl/ese_datapath.sv */
module ese_datapath #(
	parameter int DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ese_pkg::cmd_t    cmd,
	input  logic [9:0]       index,
	input  ese_pkg::val_t    value,
	input  logic             cfg_we,
	input  ese_pkg::cfg_t    cfg_data,
	output ese_pkg::stat_t   stat,
	output logic             found,
	output ese_pkg::pos_t    position
);
	import ese_pkg::*;

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = AW + 1;
	localparam int SW    = CNT_W + 1;
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	typedef logic [AW-1:0]        addr_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic signed [SW-1:0] bnd_t;

	val_t  mem [DEPTH];
	val_t  rdata_q;
	val_t  key_q;
	cnt_t  count_q;
	cnt_t  probe_q;
	addr_t mid_q;
	bnd_t  lo_q;
	bnd_t  hi_q;
	logic  first_q;
	logic  found_q;
	pos_t  position_q;

	cnt_t  p_next;
	cnt_t  p_end;
	cnt_t  cnt_m1;
	cnt_t  hmin;
	bnd_t  lo_i;
	bnd_t  hi_i;
	bnd_t  mid_i;
	bnd_t  mid_s;
	bnd_t  lo_n;
	bnd_t  hi_n;
	bnd_t  mid_n;
	addr_t rd_addr;
	logic  rd_en;
	logic  wr_en;

	// compares against the entry just read
	assign stat.eq         = (rdata_q == key_q);
	assign stat.le         = (rdata_q <= key_q);
	assign stat.count_zero = (count_q == '0);

	// probe doubling, first_q marks the entry 0 check
	assign p_next       = first_q ? cnt_t'(1) : (probe_q << 1);
	assign stat.next_in = (p_next < count_q);
	assign p_end        = (first_q || stat.le) ? p_next : probe_q;

	// initial binary range from the final probe
	assign cnt_m1             = count_q - cnt_t'(1);
	assign hmin               = (probe_q < cnt_m1) ? probe_q : cnt_m1;
	assign lo_i               = $signed({1'b0, probe_q >> 1});
	assign hi_i               = $signed({1'b0, hmin});
	assign stat.init_range_ok = (hi_i >= lo_i);
	assign mid_i              = lo_i + ((hi_i - lo_i) >>> 1);

	// narrowed binary range after a miss at the midpoint
	assign mid_s              = $signed({2'b00, mid_q});
	assign lo_n               = stat.le ? (mid_s + bnd_t'(1)) : lo_q;
	assign hi_n               = stat.le ? hi_q : (mid_s - bnd_t'(1));
	assign stat.next_range_ok = (hi_n >= lo_n);
	assign mid_n              = lo_n + ((hi_n - lo_n) >>> 1);

	// read address select
	always_comb begin
		rd_addr = '0;
		if (cmd.probe_go) begin
			rd_addr = addr_t'(p_next);
		end else if (cmd.bin_init) begin
			rd_addr = addr_t'(mid_i);
		end else if (cmd.bin_next) begin
			rd_addr = addr_t'(mid_n);
		end
	end

	assign rd_en = cmd.load_search | cmd.probe_go | cmd.bin_init | cmd.bin_next;
	assign wr_en = cmd.do_write && (32'(index) < DEPTH);

	// entry store, one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_t'(index)] <= value;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// search working registers
	always_ff @(posedge clk) begin
		if (cmd.load_search) begin
			key_q <= value;
		end
		if (rd_en) begin
			mid_q   <= rd_addr;
			first_q <= cmd.load_search;
		end
		if (cmd.probe_go) begin
			probe_q <= p_next;
		end else if (cmd.probe_end) begin
			probe_q <= p_end;
		end
		if (cmd.bin_init) begin
			lo_q <= lo_i;
			hi_q <= hi_i;
		end else if (cmd.bin_next) begin
			lo_q <= lo_n;
			hi_q <= hi_n;
		end
		if (cmd.finish_hit) begin
			position_q <= pos_t'(mid_q);
		end else if (cmd.finish_miss) begin
			position_q <= '0;
		end
	end

	// count register clamped to the store depth, and the found flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (CMP_W'(cfg_data) > CMP_W'(DEPTH)) begin
					count_q <= cnt_t'(DEPTH);
				end else begin
					count_q <= cnt_t'(cfg_data);
				end
			end
			if (cmd.finish_hit) begin
				found_q <= 1'b1;
			end else if (cmd.finish_miss) begin
				found_q <= 1'b0;
			end
		end
	end

	assign found    = found_q;
	assign position = position_q;

endmodule

/* rtl/exponential_search_engine_unit.sv */
// Exponential search over a store of signed 32-bit entries kept in ascending
// order. A write transaction (opcode 0) stores value at index in the same
// cycle it is accepted and returns nothing; busy stays low. A search
// transaction (opcode 1) checks entry 0, doubles a probe while it is below
// element_count and the entry is at most the key, then binary-searches the
// last bracket. The single store read port is the limit: at most one entry
// is read per cycle, so a search holds busy through the entry 0 check, the
// probe reads, the range setup step and the binary steps over the bracket.
// A search with a count of zero finishes at once and busy stays low.
// The result appears on the found and position outputs for exactly one
// cycle with done high, in the first cycle with busy low again; the receiver
// cannot hold it off and must take it then. The next transaction may be
// started while done is high. element_count is written through
// cfg_valid/cfg_ready only while busy is low and no transaction is being
// started, and counts above DEPTH are treated as DEPTH. Store entries hold no
// reset value and must be written before a search reads them.
module exponential_search_engine_unit #(
	parameter int DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic          opcode,
	input  logic [9:0]    index,
	input  ese_pkg::val_t value,
	output logic          done,
	output logic          found,
	output ese_pkg::pos_t position,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  ese_pkg::cfg_t cfg_data
);
	import ese_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  cfg_we;

	// configuration transaction, held off while busy or while a transaction starts
	assign cfg_ready = !busy && !start;
	assign cfg_we    = cfg_valid && cfg_ready;

	ese_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ese_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.index    (index),
		.value    (value),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.stat     (stat),
		.found    (found),
		.position (position)
	);

`ifndef ASSERT_OFF
	// a write transaction never produces a result
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_WRITE) |=> !done)
		else $error("result after write transaction");

	// every search that held busy ends with a result strobe
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("search ended without result");

	// a miss reports position zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (position == '0))
		else $error("nonzero position on miss");
`endif

endmodule

/* tb/sv/tb_exponential_search_engine_unit.sv */
module tb_exponential_search_engine_unit;
	import ese_pkg::*;

	localparam int   STORE_DEPTH   = 1024;
	localparam int   SETTLE_CYCLES = 30;
	localparam val_t VAL_MIN       = 32'sh8000_0000;
	localparam val_t VAL_MAX       = 32'sh7FFF_FFFF;

	typedef struct {
		logic found;
		pos_t position;
	} search_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       opcode;
	logic [9:0] index;
	val_t       value;
	logic       done;
	logic       found;
	pos_t       position;
	logic       cfg_valid;
	logic       cfg_ready;
	cfg_t       cfg_data;

	// shadow of the block: store contents and active entry count
	val_t entry_mem [STORE_DEPTH];
	cfg_t entry_count = '0;

	search_result_t search_results_due[$];
	search_result_t head_result;
	int             fail_count = 0;
	int             items_sent = 0;
	int             gap_odds   = 0;

	exponential_search_engine_unit #(
		.DEPTH(STORE_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.opcode   (opcode),
		.index    (index),
		.value    (value),
		.done     (done),
		.found    (found),
		.position (position),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// exponential search over the shadow store
	function automatic search_result_t lookup_key(val_t key);
		search_result_t r;
		int span, probe, lo, hi, mid;
		r.found    = 1'b0;
		r.position = '0;
		span = (entry_count > STORE_DEPTH) ? STORE_DEPTH : int'(entry_count);
		if (span == 0)
			return r;
		if (entry_mem[0] == key) begin
			r.found = 1'b1;
			return r;
		end
		// doubling phase
		probe = 1;
		while (probe < span && entry_mem[probe] <= key)
			probe = probe * 2;
		// binary phase over the last bracket
		lo = probe / 2;
		hi = (probe < span - 1) ? probe : span - 1;
		while (hi >= lo) begin
			mid = lo + (hi - lo) / 2;
			if (entry_mem[mid] == key) begin
				r.found    = 1'b1;
				r.position = pos_t'(mid);
				return r;
			end
			if (entry_mem[mid] > key)
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		return r;
	endfunction

	// search key: mostly stored values, some neighbors, extremes and noise
	function automatic val_t pick_key();
		int          span;
		int unsigned pick;
		span = (entry_count > STORE_DEPTH) ? STORE_DEPTH : int'(entry_count);
		pick = $urandom_range(0, 19);
		if (span == 0 || pick >= 17)
			return val_t'($urandom);
		if (pick < 11)
			return entry_mem[$urandom_range(0, span - 1)];
		if (pick < 15)
			return entry_mem[$urandom_range(0, span - 1)] + ($urandom_range(0, 1) ? 1 : -1);
		if (pick == 15)
			return VAL_MIN;
		return VAL_MAX;
	endfunction

	task automatic pause_sender(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// one transaction on the command port, predicted on acceptance
	task automatic send_item(op_t op, logic [9:0] idx, val_t val);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
			pause_sender($urandom_range(1, 18));
		@(negedge clk);
		start  <= 1'b1;
		opcode <= op;
		index  <= idx;
		value  <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		if (op == OP_WRITE)
			entry_mem[idx] = val;
		else
			search_results_due.push_back(lookup_key(val));
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (search_results_due.size() != 0)
			@(posedge clk);
	endtask

	// count register only changes while the block is idle
	task automatic write_element_count(cfg_t n);
		drain_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= n;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		entry_count = n;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ascending run of values at entries 0..n-1, duplicates allowed
	task automatic load_sorted(int n, val_t base, int unsigned step_max);
		longint v;
		v = base;
		for (int i = 0; i < n; i++) begin
			send_item(OP_WRITE, 10'(i), val_t'(v));
			v = v + $urandom_range(0, step_max);
			if (v > 64'sd2147483647)
				v = 64'sd2147483647;
		end
	endtask

	// searches with no entries taking part, store still unwritten
	task automatic test_empty_count();
		send_item(OP_SEARCH, 10'h3FF, 32'sd0);
		send_item(OP_SEARCH, 10'h000, VAL_MIN);
		write_element_count(11'd0);
	endtask

	task automatic load_full_store();
		load_sorted(STORE_DEPTH, VAL_MIN, 32'd8_000_000);
		send_item(OP_WRITE, 10'h3FF, VAL_MAX);
	endtask

	task automatic test_full_range();
		write_element_count(cfg_t'(STORE_DEPTH));
		send_item(OP_SEARCH, 10'd0, VAL_MIN);
		send_item(OP_SEARCH, 10'd0, VAL_MAX);
		send_item(OP_SEARCH, 10'd0, entry_mem[512]);
		send_item(OP_SEARCH, 10'd0, entry_mem[777] + 1);
	endtask

	// single entry, count above depth, count just past depth
	task automatic test_count_limits();
		write_element_count(11'd1);
		send_item(OP_SEARCH, 10'd0, entry_mem[0]);
		send_item(OP_SEARCH, 10'd0, entry_mem[1]);
		write_element_count(11'h7FF);
		send_item(OP_SEARCH, 10'd0, VAL_MAX);
		send_item(OP_SEARCH, 10'd0, entry_mem[600]);
		write_element_count(cfg_t'(STORE_DEPTH + 1));
		send_item(OP_SEARCH, 10'd0, entry_mem[1000]);
	endtask

	// repeated keys, then one entry out of order
	task automatic test_duplicates_and_disorder();
		write_element_count(11'd64);
		for (int i = 41; i <= 43; i++)
			send_item(OP_WRITE, 10'(i), entry_mem[40]);
		send_item(OP_SEARCH, 10'd0, entry_mem[40]);
		send_item(OP_WRITE, 10'd3, VAL_MAX);
		send_item(OP_SEARCH, 10'd0, VAL_MAX);
		send_item(OP_SEARCH, 10'd0, entry_mem[50]);
	endtask

	// keys below the first and above the last entry
	task automatic test_small_set_bounds();
		load_sorted(4, -32'sd50, 32'd20);
		write_element_count(11'd4);
		send_item(OP_SEARCH, 10'd0, -32'sd1000);
		send_item(OP_SEARCH, 10'd0, 32'sd1000);
		send_item(OP_SEARCH, 10'd0, VAL_MIN);
	endtask

	task automatic test_random_traffic();
		int          goal, n, plan;
		val_t        base;
		int unsigned step_max;
		// run total of about 2000 transactions
		goal = 2000;
		while (items_sent < goal) begin
			// no idling near the end of the run
			if (goal - items_sent < 300)
				gap_odds = 0;
			else
				gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
			plan = $urandom_range(0, 9);
			if (plan < 6) begin
				// fresh sorted set, then searches over it
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(128, 384)
					: $urandom_range(1, 40);
				base = ($urandom_range(0, 3) == 0) ? VAL_MIN : val_t'($urandom);
				case ($urandom_range(0, 2))
					0: step_max = 3;
					1: step_max = 1000;
					default: step_max = 32'h0100_0000;
				endcase
				load_sorted(n, base, step_max);
				if ($urandom_range(0, 4) != 0)
					write_element_count(cfg_t'(n));
				else
					write_element_count(cfg_t'($urandom_range(0, 2047)));
				repeat ($urandom_range(10, 30))
					send_item(OP_SEARCH, 10'($urandom), pick_key());
			end else if (plan < 8) begin
				// scattered writes that may break the ordering
				repeat ($urandom_range(1, 8))
					send_item(OP_WRITE, 10'($urandom), val_t'($urandom));
				repeat ($urandom_range(5, 20))
					send_item(OP_SEARCH, 10'($urandom), pick_key());
			end else begin
				// interleaved writes and searches
				repeat ($urandom_range(10, 30)) begin
					if ($urandom_range(0, 9) < 3)
						send_item(OP_WRITE, 10'($urandom), val_t'($urandom));
					else
						send_item(OP_SEARCH, 10'($urandom), pick_key());
				end
			end
		end
		gap_odds = 0;
	endtask

	// compare each result with the oldest pending search
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (search_results_due.size() == 0) begin
				$display("%0t: result with no search pending, expected none, actual found %0b position %0d",
					$time, found, position);
				fail_count++;
			end else begin
				head_result = search_results_due.pop_front();
				if (found !== head_result.found) begin
					$display("%0t: found mismatch, expected %0b, actual %0b",
						$time, head_result.found, found);
					fail_count++;
				end
				if (position !== head_result.position) begin
					$display("%0t: position mismatch, expected %0d, actual %0d",
						$time, head_result.position, position);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		opcode    = 1'b0;
		index     = '0;
		value     = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_count();
		load_full_store();
		test_full_range();
		test_count_limits();
		test_duplicates_and_disorder();
		test_small_set_bounds();
		test_random_traffic();

		drain_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
